// ===== rtl/hwsm_pkg.sv =====
// Shared types and constants for the hall wheel speed meter.
// No dependencies; imported by every module of the block.
package hwsm_pkg;

  localparam int TDATA_IN_W  = 48;
  localparam int TDATA_OUT_W = 48;
  localparam int TUSER_IN_W  = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam int TIME_W  = 32;
  localparam int CIRC_W  = 12;
  localparam int POT_W   = 10;
  localparam int VAL_W   = 16;

  localparam logic [1:0] KIND_HALL  = 2'd0;
  localparam logic [1:0] KIND_CHECK = 2'd1;
  localparam logic [1:0] KIND_POT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CIRC    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic [CIRC_W-1:0] CIRC_RESET    = 12'd2180;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000000;

  // quotient width: circ * 57600 stays below 2^28
  localparam int DIV_W     = 28;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  localparam logic [15:0]      SPEED_SCALE = 16'd57600;
  localparam logic [DIV_W-1:0] RPM_SCALE   = 28'd60000000;

  // floor(x/10) = (x * 838861) >> 23 for x < 2^20
  localparam int SUM_W     = 20;
  localparam int RECIP_W   = 20;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int RECIP_SH  = 23;
  localparam logic [RECIP_W-1:0] RECIP10 = 20'd838861;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic apply;
    logic smooth_mul;
    logic smooth_upd;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       div_done;
  } dp_status_t;

endpackage

// ===== rtl/hwsm_div.sv =====
// Two-lane restoring divider sharing one 32-bit divisor, one bit per cycle.
// Depends on hwsm_pkg.
module hwsm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [hwsm_pkg::DIV_W-1:0] num_a,
  input  logic [hwsm_pkg::DIV_W-1:0] num_b,
  input  logic [31:0]                den,
  output logic                       done,
  output logic [hwsm_pkg::DIV_W-1:0] quo_a,
  output logic [hwsm_pkg::DIV_W-1:0] quo_b
);
  import hwsm_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [31:0]          den_r;
  logic [31:0]          rem_a_r, rem_b_r;
  logic [DIV_W-1:0]     sh_a_r, sh_b_r;
  logic [32:0]          step_a, step_b;

  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nb,
                                           input logic [31:0] d);
    logic [32:0] trial;
    logic [32:0] diff;
    trial = {rem, nb};
    diff  = trial - {1'b0, d};
    if (!diff[32]) begin
      return {diff[31:0], 1'b1};
    end
    return {trial[31:0], 1'b0};
  endfunction

  assign step_a = div_step(rem_a_r, sh_a_r[DIV_W-1], den_r);
  assign step_b = div_step(rem_b_r, sh_b_r[DIV_W-1], den_r);

  assign done  = busy_r && (cnt_r == DIV_LAST);
  assign quo_a = sh_a_r;
  assign quo_b = sh_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r   <= den;
      rem_a_r <= '0;
      rem_b_r <= '0;
      sh_a_r  <= num_a;
      sh_b_r  <= num_b;
    end else if (busy_r) begin
      rem_a_r <= step_a[32:1];
      rem_b_r <= step_b[32:1];
      sh_a_r  <= {sh_a_r[DIV_W-2:0], step_a[0]};
      sh_b_r  <= {sh_b_r[DIV_W-2:0], step_b[0]};
    end
  end

endmodule

// ===== rtl/hwsm_dp.sv =====
// Datapath: config registers, meter state, divider, smoothing, result register.
// Depends on hwsm_pkg and hwsm_div.
module hwsm_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hwsm_pkg::dp_cmd_t               cmd,
  output hwsm_pkg::dp_status_t            status,
  input  logic [hwsm_pkg::TUSER_IN_W-1:0] in_tuser,
  input  logic [hwsm_pkg::TDATA_IN_W-1:0] in_tdata,
  input  logic                            cfg_we,
  input  logic [hwsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hwsm_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [hwsm_pkg::TDATA_OUT_W-1:0] out_tdata
);
  import hwsm_pkg::*;

  logic [CIRC_W-1:0] circ_r;
  logic [TIME_W-1:0] timeout_r;

  logic [1:0]        kind_r;
  logic [TIME_W-1:0] t_r;
  logic [POT_W-1:0]  pot_r;

  logic [TIME_W-1:0] prev_edge_r;
  logic [VAL_W-1:0]  speed_r;
  logic [VAL_W-1:0]  rpm_r;
  logic [VAL_W-1:0]  seen_speed_r;
  logic [TIME_W-1:0] change_time_r;
  logic [POT_W-1:0]  steer_r;

  logic [PROD_W-1:0] prod_r;
  logic [VAL_W:0]    rsum_r;

  logic [TIME_W-1:0] dt_raw, dt, elapsed;
  logic [DIV_W-1:0]  speed_num, quo_s, quo_r;
  logic [VAL_W-1:0]  inst_s, inst_r;
  logic [SUM_W-1:0]  ssum;
  logic              div_done;

  assign dt_raw    = t_r - prev_edge_r;
  assign dt        = (dt_raw == '0) ? TIME_W'(1) : dt_raw;
  assign speed_num = DIV_W'(circ_r) * DIV_W'(SPEED_SCALE);
  assign elapsed   = t_r - change_time_r;

  hwsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num_a (speed_num),
    .num_b (RPM_SCALE),
    .den   (dt),
    .done  (div_done),
    .quo_a (quo_s),
    .quo_b (quo_r)
  );

  assign inst_s = (|quo_s[DIV_W-1:VAL_W]) ? '1 : quo_s[VAL_W-1:0];
  assign inst_r = (|quo_r[DIV_W-1:VAL_W]) ? '1 : quo_r[VAL_W-1:0];
  assign ssum   = SUM_W'(inst_s) + {1'b0, speed_r, 3'b000} + SUM_W'(speed_r);

  assign status.kind     = kind_r;
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      circ_r    <= CIRC_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CIRC:    circ_r    <= cfg_data[CIRC_W-1:0];
        CFG_TIMEOUT: timeout_r <= cfg_data[TIME_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_tuser;
      t_r    <= in_tdata[TIME_W-1:0];
      pot_r  <= in_tdata[TIME_W +: POT_W];
    end
    if (cmd.smooth_mul) begin
      prod_r <= PROD_W'(ssum) * PROD_W'(RECIP10);
      rsum_r <= {1'b0, inst_r} + {1'b0, rpm_r};
    end
    if (cmd.load_out) begin
      out_tdata <= {6'd0, steer_r, rpm_r, speed_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_edge_r   <= '0;
      speed_r       <= '0;
      rpm_r         <= '0;
      seen_speed_r  <= '0;
      change_time_r <= '0;
      steer_r       <= '0;
    end else begin
      if (cmd.div_start) begin
        prev_edge_r <= t_r;
      end
      if (cmd.smooth_upd) begin
        speed_r <= prod_r[RECIP_SH +: VAL_W];
        rpm_r   <= rsum_r[VAL_W:1];
      end
      if (cmd.apply) begin
        case (kind_r)
          KIND_CHECK: begin
            if (speed_r == seen_speed_r) begin
              if (elapsed > timeout_r) begin
                speed_r <= '0;
                rpm_r   <= '0;
              end
            end else begin
              change_time_r <= t_r;
              seen_speed_r  <= speed_r;
            end
          end
          KIND_POT: steer_r <= {~pot_r[POT_W-1], pot_r[POT_W-2:0]};
          default:  ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/hwsm_ctrl.sv =====
// Controller FSM: sequences capture, division, smoothing and result load.
// Depends on hwsm_pkg.
module hwsm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output hwsm_pkg::dp_cmd_t    cmd,
  input  hwsm_pkg::dp_status_t status
);
  import hwsm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DIV, S_MUL, S_UPD, S_LOAD
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd            = '0;
    cmd.capture    = (state_r == S_IDLE) && in_tvalid;
    cmd.div_start  = (state_r == S_EXEC) && (status.kind == KIND_HALL);
    cmd.apply      = (state_r == S_EXEC) && (status.kind != KIND_HALL);
    cmd.smooth_mul = (state_r == S_MUL);
    cmd.smooth_upd = (state_r == S_UPD);
    cmd.load_out   = (state_r == S_LOAD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_LOAD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (in_tvalid) state_r <= S_EXEC;
        S_EXEC: state_r <= (status.kind == KIND_HALL) ? S_DIV : S_LOAD;
        S_DIV:  if (status.div_done) state_r <= S_MUL;
        S_MUL:  state_r <= S_UPD;
        S_UPD:  state_r <= S_LOAD;
        S_LOAD: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/hall_wheel_speed_meter.sv =====
// Top level of the hall wheel speed meter: controller plus datapath.
// Depends on hwsm_pkg, hwsm_ctrl, hwsm_dp (and hwsm_div below it).
//
//   channel | direction | handshake              | payload
//   in_     | slave     | in_tvalid / in_tready  | tdata: time_us, pot_value; tuser: kind
//   out_    | master    | out_tvalid / out_tready| tdata: speed_kmh_q4, rpm_q0, steer
//   cfg_    | slave     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A hall edge runs from capture through divider start, the 28-step two-lane
// divider, smoothing and result load; check ticks and pot samples go through apply and load.
// One item is in work at a time; the next is taken while a result waits.
// A stalled output holds the finished item in its final state until taken.
// Reset is synchronous; config registers return to their reset values.
module hall_wheel_speed_meter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hwsm_pkg::TDATA_IN_W-1:0]  in_tdata,   // time_us[31:0], pot_value[41:32]
  input  logic [hwsm_pkg::TUSER_IN_W-1:0]  in_tuser,   // kind[1:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hwsm_pkg::TDATA_OUT_W-1:0] out_tdata,  // speed[15:0], rpm[31:16], steer[41:32]
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hwsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hwsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hwsm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  hwsm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  hwsm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

endmodule
